// ===== rtl/ordered_array_insert_remove_find_defines.svh =====
// Assertion helpers; clock and reset are taken from the enclosing scope.
`ifndef ORDERED_ARRAY_INSERT_REMOVE_FIND_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_REMOVE_FIND_DEFINES_SVH

`define OAIRF_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`define OAIRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/oairf_pkg.sv =====
`timescale 1ns / 1ps

package oairf_pkg;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_FIND   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   localparam int LANES     = 8;
   localparam int LANE_BITS = 3;

   typedef struct packed {
      logic [1:0]  func;
      logic [6:0]  position;
      logic [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic [5:0]  match_position;
      logic        match_found;
      logic [6:0]  fill_count;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic remove;
      logic capture;
      logic find;
      logic shift;
   } cell_ctrl_type;

endpackage

// ===== rtl/oairf_cell.sv =====
`timescale 1ns / 1ps

module oairf_cell #(
   parameter int WIDTH = 32,
   parameter int INDEX = 0,
   parameter int PW    = 7
) (
   input  logic                      clock,
   input  logic                      reset,
   input  oairf_pkg::cell_ctrl_type  ctrl,
   input  logic [PW-1:0]             position,
   input  logic [PW-1:0]             count,
   input  logic [WIDTH-1:0]          item_value,
   input  logic [WIDTH-1:0]          left_value,
   input  logic [WIDTH-1:0]          right_value,
   input  logic                      next_hit,
   input  logic [WIDTH-1:0]          next_data,
   output logic [WIDTH-1:0]          entry,
   output logic                      scan_hit,
   output logic [WIDTH-1:0]          scan_data
);

   localparam logic [PW-1:0] IDX      = PW'(INDEX);
   localparam logic [PW-1:0] IDX_NEXT = PW'(INDEX + 1);

   logic [WIDTH-1:0] entry_ff;
   logic [WIDTH-1:0] entry_in;
   logic             scan_hit_ff;
   logic             scan_hit_in;
   logic [WIDTH-1:0] scan_data_ff;
   logic [WIDTH-1:0] scan_data_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (position == IDX) begin
            entry_in = item_value;
         end else if (IDX > position && IDX <= count) begin
            entry_in = left_value;
         end
      end
      if (ctrl.remove && IDX >= position && IDX_NEXT < count) begin
         entry_in = right_value;
      end
   end

   always_comb begin
      scan_hit_in  = scan_hit_ff;
      scan_data_in = scan_data_ff;
      if (ctrl.capture) begin
         scan_data_in = entry_ff;
         if (ctrl.find) begin
            scan_hit_in = (entry_ff == item_value) && (IDX < count);
         end else begin
            scan_hit_in = (IDX == position);
         end
      end else if (ctrl.shift) begin
         scan_hit_in  = next_hit;
         scan_data_in = next_data;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      scan_data_ff <= scan_data_in;
      if (reset) begin
         scan_hit_ff <= 1'b0;
      end else begin
         scan_hit_ff <= scan_hit_in;
      end
   end

   assign entry     = entry_ff;
   assign scan_hit  = scan_hit_ff;
   assign scan_data = scan_data_ff;

endmodule

// ===== rtl/oairf_scan.sv =====
`timescale 1ns / 1ps

module oairf_scan #(
   parameter int WIDTH = 32
) (
   input  logic [oairf_pkg::LANES-1:0]     hit,
   input  logic [WIDTH-1:0]                data [oairf_pkg::LANES],
   output logic                            hit_any,
   output logic [oairf_pkg::LANE_BITS-1:0] hit_lane,
   output logic [WIDTH-1:0]                hit_data
);

   always_comb begin
      hit_any  = |hit;
      hit_lane = '0;
      hit_data = '0;
      for (int j = oairf_pkg::LANES - 1; j >= 0; j--) begin
         if (hit[j]) begin
            hit_lane = oairf_pkg::LANE_BITS'(j);
            hit_data = data[j];
         end
      end
   end

endmodule

// ===== rtl/ordered_array_insert_remove_find.sv =====
`timescale 1ns / 1ps
// Ordered array of DEPTH words held in a row of cells with a fill count.
// One request at a time: insert and any refused request go from accept to the
// done state, which puts the result into the output register; read, remove and
// find pass a scan state first. At accept the cells from the position on shift
// for insert or remove, and for read, remove or find every cell latches a hit
// flag; an 8-lane window then walks the hit flags toward cell 0, 8 cells a
// cycle, and stops at the first hit or the last window. The result waits in an
// output register, and a new request is taken while it waits.
`include "ordered_array_insert_remove_find_defines.svh"

module ordered_array_insert_remove_find #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  oairf_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output oairf_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = (CW > 7) ? CW : 7;
   localparam int XW = CW + 4;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 base_ff, base_in;
   logic [1:0]                    op_ff, op_in;
   logic [1:0]                    status_ff, status_in;
   logic [WIDTH-1:0]              res_data_ff, res_data_in;
   logic [CW-1:0]                 res_pos_ff, res_pos_in;
   logic                          res_found_ff, res_found_in;
   oairf_pkg::rsp_type            rsp_ff, rsp_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   logic                          req_acc;
   logic [PW-1:0]                 pos_ext;
   logic [PW-1:0]                 cnt_ext;
   logic [WIDTH-1:0]              val_w;
   logic [1:0]                    status_dec;
   logic                          ok_dec;
   logic                          last_window;
   oairf_pkg::cell_ctrl_type      ctrl;

   logic [WIDTH-1:0]              entry_w [DEPTH];
   logic                          hit_w [DEPTH];
   logic [WIDTH-1:0]              sdata_w [DEPTH];

   logic [oairf_pkg::LANES-1:0]     win_hit;
   logic [WIDTH-1:0]                win_data [oairf_pkg::LANES];
   logic                            scan_hit_any;
   logic [oairf_pkg::LANE_BITS-1:0] scan_lane;
   logic [WIDTH-1:0]                scan_data;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign pos_ext   = PW'(req_data.position);
   assign cnt_ext   = PW'(count_ff);
   assign val_w     = WIDTH'(req_data.item_value);
   assign last_window = (XW'(base_ff) + XW'(oairf_pkg::LANES)) >= XW'(DEPTH);

   always_comb begin
      status_dec = oairf_pkg::STATUS_OK;
      unique case (req_data.func) inside
         oairf_pkg::FUNC_INSERT: begin
            if (count_ff == CW'(DEPTH)) begin
               status_dec = oairf_pkg::STATUS_FULL;
            end else if (pos_ext > cnt_ext) begin
               status_dec = oairf_pkg::STATUS_RANGE;
            end
         end
         oairf_pkg::FUNC_REMOVE, oairf_pkg::FUNC_READ: begin
            if (pos_ext >= cnt_ext) begin
               status_dec = oairf_pkg::STATUS_RANGE;
            end
         end
         default: begin
            if (count_ff == '0) begin
               status_dec = oairf_pkg::STATUS_RANGE;
            end
         end
      endcase
      ok_dec = (status_dec == oairf_pkg::STATUS_OK);
   end

   always_comb begin
      ctrl.insert  = req_acc && ok_dec && (req_data.func == oairf_pkg::FUNC_INSERT);
      ctrl.remove  = req_acc && ok_dec && (req_data.func == oairf_pkg::FUNC_REMOVE);
      ctrl.capture = req_acc && ok_dec && (req_data.func != oairf_pkg::FUNC_INSERT);
      ctrl.find    = (req_data.func == oairf_pkg::FUNC_FIND);
      ctrl.shift   = (state_ff == ST_SCAN) && !scan_hit_any && !last_window;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WIDTH-1:0] left_v;
      logic [WIDTH-1:0] right_v;
      logic             next_hit_v;
      logic [WIDTH-1:0] next_data_v;

      if (i == 0) begin : g_first
         assign left_v = val_w;
      end else begin : g_mid
         assign left_v = entry_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_inner
         assign right_v = entry_w[i+1];
      end

      if (i + oairf_pkg::LANES < DEPTH) begin : g_feed
         assign next_hit_v  = hit_w[i+oairf_pkg::LANES];
         assign next_data_v = sdata_w[i+oairf_pkg::LANES];
      end else begin : g_tail
         assign next_hit_v  = 1'b0;
         assign next_data_v = '0;
      end

      oairf_cell #(
         .WIDTH (WIDTH),
         .INDEX (i),
         .PW    (PW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .position    (pos_ext),
         .count       (cnt_ext),
         .item_value  (val_w),
         .left_value  (left_v),
         .right_value (right_v),
         .next_hit    (next_hit_v),
         .next_data   (next_data_v),
         .entry       (entry_w[i]),
         .scan_hit    (hit_w[i]),
         .scan_data   (sdata_w[i])
      );
   end

   for (genvar j = 0; j < oairf_pkg::LANES; j++) begin : g_win
      if (j < DEPTH) begin : g_used
         assign win_hit[j]  = hit_w[j];
         assign win_data[j] = sdata_w[j];
      end else begin : g_pad
         assign win_hit[j]  = 1'b0;
         assign win_data[j] = '0;
      end
   end

   oairf_scan #(
      .WIDTH (WIDTH)
   ) u_scan (
      .hit      (win_hit),
      .data     (win_data),
      .hit_any  (scan_hit_any),
      .hit_lane (scan_lane),
      .hit_data (scan_data)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      res_data_in  = res_data_ff;
      res_pos_in   = res_pos_ff;
      res_found_in = res_found_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               op_in        = req_data.func;
               status_in    = status_dec;
               res_data_in  = '0;
               res_pos_in   = '0;
               res_found_in = 1'b0;
               base_in      = '0;
               if (ctrl.insert) begin
                  count_in = count_ff + CW'(1);
               end else if (ctrl.remove) begin
                  count_in = count_ff - CW'(1);
               end
               state_in = ctrl.capture ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_hit_any) begin
               if (op_ff == oairf_pkg::FUNC_FIND) begin
                  res_found_in = 1'b1;
                  res_pos_in   = CW'(XW'(base_ff) + XW'(scan_lane));
               end else begin
                  res_data_in = scan_data;
               end
               state_in = ST_DONE;
            end else if (last_window) begin
               state_in = ST_DONE;
            end else begin
               base_in = CW'(XW'(base_ff) + XW'(oairf_pkg::LANES));
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.data_out       = 32'(res_data_ff);
               rsp_in.match_position = 6'(res_pos_ff);
               rsp_in.match_found    = res_found_ff;
               rsp_in.fill_count     = 7'(count_ff);
               rsp_in.status         = status_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      op_ff        <= op_in;
      status_ff    <= status_in;
      res_data_ff  <= res_data_in;
      res_pos_ff   <= res_pos_in;
      res_found_ff <= res_found_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `OAIRF_ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(DEPTH), "fill count above depth")
   `OAIRF_ASSERT_NEXT(a_count_hold, !req_acc, $stable(count_ff), "fill count moved without request")
   `OAIRF_ASSERT_NEXT(a_insert_grow, ctrl.insert, count_ff == $past(count_ff) + CW'(1), "insert did not grow count")
   `OAIRF_ASSERT_NEXT(a_scan_end, (state_ff == ST_SCAN) && last_window, state_ff != ST_SCAN, "scan ran past last window")
   `OAIRF_ASSERT_ALWAYS(a_found_ok, !rsp_valid_ff || !rsp_ff.match_found || rsp_ff.status == oairf_pkg::STATUS_OK, "match on refused request")

endmodule
